// ===== sv/gha_pkg.sv =====
// Shared operation, status and kind codes for the generational handle allocator.
`default_nettype none

package gha_pkg;

    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_CHECK  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [7:0] KIND_PAGE = 8'd1;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned GEN_W = 16;

    typedef logic [GEN_W-1:0] t_gen;

endpackage

`default_nettype wire

// ===== sv/generational_handle_allocator_top.sv =====
// Generational handle allocator: create, free and check slot handles.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low; busy is
//   low whenever reset is released, so one request can be issued every cycle.
//   i_func selects create, free or check; the handle fields are ignored on
//   create. Every request produces exactly one result, shown on the o_ ports
//   for one cycle with o_done high, starting at the edge after the accepting
//   edge. Results return in request order; the receiver cannot stall them.
//   Throughput is one request per cycle. A request reads the generation
//   memory at its accepting edge and updates it at the next edge; the next
//   request gets the written value through a bypass register, and the free
//   stack keeps its two top entries in registers with a look-ahead read, so
//   a create right behind a free or a create sees the updated stack.
//   Reset (synchronous, active low) empties the free stack and clears the
//   fresh slot count; slots at or above that count read as generation zero,
//   so the generation memory needs no clearing pass.
`default_nettype none

module generational_handle_allocator_top
    import gha_pkg::*;
#(
    parameter int unsigned SLOTS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_func,
    input  wire logic [IDX_W-1:0]  i_handle_index,
    input  wire logic [GEN_W-1:0]  i_handle_gen,
    input  wire logic [7:0]        i_handle_kind,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [7:0]             o_out_index,
    output logic [GEN_W-1:0]       o_out_gen,
    output logic [7:0]             o_out_kind
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(SLOTS);

    // storage
    t_gen             gen_mem [SLOTS];
    logic [AW-1:0]    stk_mem [SLOTS];

    // request stage
    logic             r_v;
    logic [1:0]       r_func;
    logic [IDX_W-1:0] r_idx;
    t_gen             r_hgen;
    logic [7:0]       r_kind;
    t_gen             r_gen_q;
    logic             r_fwd;
    t_gen             r_fwd_data;

    // allocator state
    logic [CW-1:0]    r_fresh, n_fresh;
    logic [CW-1:0]    r_depth, n_depth;
    logic [AW-1:0]    r_top, n_top;
    logic [AW-1:0]    r_below, n_below;
    logic [AW-1:0]    r_stk_q;

    // result
    logic             r_done;
    logic [1:0]       r_status, n_status;
    logic [7:0]       r_oidx, n_oidx;
    t_gen             r_ogen, n_ogen;
    logic [7:0]       r_okind, n_okind;

    logic             acc;
    logic [AW-1:0]    a_slot;
    logic [AW-1:0]    a_ra;
    logic [AW-1:0]    s_ra;
    logic             s_re;

    logic             b_create, b_free, b_check;
    logic             b_fresh_av, b_stack_av;
    logic [AW-1:0]    b_slot;
    logic [IDX_W-1:0] b_slot_x;
    t_gen             b_mem_val, b_gen_cur, b_gen_new, b_gen_bump;
    logic             b_in_range, b_valid;
    logic             b_create_ok, b_pop, b_push;
    logic             b_we;
    logic [AW-1:0]    b_wa;
    t_gen             b_wd;

    assign busy = ~i_rst_n;
    assign acc  = start & ~busy;

    // Stage B: resolve the request held in the input register
    always_comb begin
        b_create   = r_v && (r_func == FUNC_CREATE);
        b_free     = r_v && (r_func == FUNC_FREE);
        b_check    = r_v && (r_func == FUNC_CHECK);
        b_fresh_av = r_fresh < SLOTS_C;
        b_stack_av = r_depth != '0;
        b_slot     = b_fresh_av ? r_fresh[AW-1:0] : r_top;
        b_slot_x   = IDX_W'(b_slot);
        b_mem_val  = r_fwd ? r_fwd_data : r_gen_q;
        b_in_range = {1'b0, r_idx} < SLOTS_X;

        // slots never handed out read as generation zero
        if (r_func == FUNC_CREATE) begin
            b_gen_cur = b_fresh_av ? '0 : b_mem_val;
        end else if ({1'b0, r_idx} >= (IDX_W + 1)'(r_fresh)) begin
            b_gen_cur = '0;
        end else begin
            b_gen_cur = b_mem_val;
        end

        b_valid = (r_kind == KIND_PAGE) && (r_hgen != '0) && b_in_range
                  && (r_hgen == b_gen_cur);

        b_gen_new  = (b_gen_cur == '0) ? t_gen'(1) : b_gen_cur;
        b_gen_bump = b_gen_cur + t_gen'(1);
        if (b_gen_bump == '0) begin
            b_gen_bump = t_gen'(1);
        end

        b_create_ok = b_create && (b_fresh_av || b_stack_av);
        b_pop       = b_create && !b_fresh_av && b_stack_av;
        b_push      = b_free && b_valid && (r_depth < SLOTS_C);

        b_we = b_create_ok || b_push;
        b_wa = b_create ? b_slot : r_idx[AW-1:0];
        b_wd = b_create ? b_gen_new : b_gen_bump;

        n_fresh = r_fresh;
        if (b_create && b_fresh_av) begin
            n_fresh = r_fresh + CW'(1);
        end

        n_depth = r_depth;
        n_top   = r_top;
        n_below = r_below;
        if (b_push) begin
            n_depth = r_depth + CW'(1);
            n_top   = r_idx[AW-1:0];
            n_below = r_top;
        end else if (b_pop) begin
            n_depth = r_depth - CW'(1);
            n_top   = r_below;
            n_below = r_stk_q;
        end

        n_status = ST_REJECT;
        n_oidx   = '0;
        n_ogen   = '0;
        n_okind  = '0;
        if (b_create) begin
            if (b_create_ok) begin
                n_status = ST_OK;
                n_oidx   = b_slot_x[7:0];
                n_ogen   = b_gen_new;
                n_okind  = KIND_PAGE;
            end else begin
                n_status = ST_FULL;
            end
        end else if (b_free) begin
            n_status = b_push ? ST_OK : ST_REJECT;
        end else if (b_check) begin
            n_status = b_valid ? ST_OK : ST_REJECT;
        end
    end

    // Stage A: pick the generation read address against the post-B state
    always_comb begin
        a_slot = (n_fresh < SLOTS_C) ? n_fresh[AW-1:0] : n_top;
        a_ra   = (i_func == FUNC_CREATE) ? a_slot : i_handle_index[AW-1:0];
        // prefetch the entry under the new second-from-top
        s_re   = n_depth >= CW'(3);
        s_ra   = AW'(n_depth - CW'(3));
    end

    always_ff @(posedge i_clk) begin
        r_gen_q <= gen_mem[a_ra];
        if (b_we) begin
            gen_mem[b_wa] <= b_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_re) begin
            r_stk_q <= stk_mem[s_ra];
        end
        if (b_push) begin
            stk_mem[r_depth[AW-1:0]] <= r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_done  <= 1'b0;
            r_fresh <= '0;
            r_depth <= '0;
        end else begin
            r_v     <= acc;
            r_done  <= r_v;
            r_fresh <= n_fresh;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= i_func;
        r_idx      <= i_handle_index;
        r_hgen     <= i_handle_gen;
        r_kind     <= i_handle_kind;
        // bypass the write landing on the same edge as the read
        r_fwd      <= b_we && (b_wa == a_ra);
        r_fwd_data <= b_wd;
        r_top      <= n_top;
        r_below    <= n_below;
        r_status   <= n_status;
        r_oidx     <= n_oidx;
        r_ogen     <= n_ogen;
        r_okind    <= n_okind;
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_index = r_oidx;
    assign o_out_gen   = r_ogen;
    assign o_out_kind  = r_okind;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 o_done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, 2))
        else $error("result without a transaction");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fresh <= SLOTS_C) && (r_depth <= SLOTS_C))
        else $error("fresh count or free depth beyond slot count");

    a_created_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_out_kind == KIND_PAGE)) |-> ((o_status == ST_OK) && (o_out_gen != '0)))
        else $error("created handle has zero generation or bad status");

endmodule

`default_nettype wire
